@@ hw/rtl/calclk_pkg.sv @@
// Shared types, constants and calendar functions for the calendar clock.
package calclk_pkg;

    localparam int unsigned YearW   = 14;
    localparam int unsigned MonthW  = 4;
    localparam int unsigned DayW    = 5;
    localparam int unsigned HourW   = 5;
    localparam int unsigned MinuteW = 6;
    localparam int unsigned SecondW = 6;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = YearW;

    localparam logic [SecondW-1:0] SecondMax = 6'd59;
    localparam logic [MinuteW-1:0] MinuteMax = 6'd59;
    localparam logic [HourW-1:0]   HourMax   = 5'd23;
    localparam logic [MonthW-1:0]  MonthMax  = 4'd12;
    localparam logic [YearW-1:0]   YearMax   = 14'd9999;

    localparam logic [DayW-1:0] DaysLong  = 5'd31;
    localparam logic [DayW-1:0] DaysShort = 5'd30;
    localparam logic [DayW-1:0] DaysFeb   = 5'd28;
    localparam logic [DayW-1:0] DaysLeap  = 5'd29;

    // multiplicative inverse of 25 modulo 2^14, and the largest multiple index
    localparam logic [YearW-1:0] Inv25   = 14'd7209;
    localparam logic [YearW-1:0] Lim25   = 14'd655;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_REF_YEAR   = 3'd0,
        CFG_REF_MONTH  = 3'd1,
        CFG_REF_DAY    = 3'd2,
        CFG_REF_HOUR   = 3'd3,
        CFG_REF_MINUTE = 3'd4,
        CFG_REF_SECOND = 3'd5
    } cfg_index_t;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_LOAD = 1'b1
    } command_t;

    typedef enum logic [MonthW-1:0] {
        MON_FEB = 4'd2,
        MON_APR = 4'd4,
        MON_JUN = 4'd6,
        MON_SEP = 4'd9,
        MON_NOV = 4'd11
    } month_code_t;

    // field order matches significance, so the packed value compares as a whole
    typedef struct packed {
        logic [YearW-1:0]   year;
        logic [MonthW-1:0]  month;
        logic [DayW-1:0]    day;
        logic [HourW-1:0]   hour;
        logic [MinuteW-1:0] minute;
        logic [SecondW-1:0] second;
    } time_t;

    localparam time_t ResetTime = '{
        year:   14'd2000,
        month:  4'd1,
        day:    5'd1,
        hour:   5'd0,
        minute: 6'd0,
        second: 6'd0
    };

    // divisible by 4, and not by 100 unless by 400; 25 | y via inverse multiply
    function automatic logic is_leap(input logic [YearW-1:0] y);
        logic [2*YearW-1:0] prod;
        logic               div25;
        prod  = {{YearW{1'b0}}, y} * {{YearW{1'b0}}, Inv25};
        div25 = (prod[YearW-1:0] <= Lim25);
        return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
    endfunction

    function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] m,
                                                     input logic leap);
        logic [DayW-1:0] len;
        case (m)
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = DaysShort;
            MON_FEB:                            len = leap ? DaysLeap : DaysFeb;
            default:                            len = DaysLong;
        endcase
        return len;
    endfunction

endpackage

@@ hw/rtl/calclk_cfg.sv @@
// Reference date registers written through the configuration port.
module calclk_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [calclk_pkg::CfgIdxW-1:0]      wr_index,
    input  logic [calclk_pkg::CfgDataW-1:0]     wr_data,
    output calclk_pkg::time_t                   ref_time
);

    calclk_pkg::time_t ref_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= calclk_pkg::ResetTime;
        end
        else if (wr_en)
        begin
            case (wr_index)
                calclk_pkg::CFG_REF_YEAR:   ref_reg.year   <= wr_data[calclk_pkg::YearW-1:0];
                calclk_pkg::CFG_REF_MONTH:  ref_reg.month  <= wr_data[calclk_pkg::MonthW-1:0];
                calclk_pkg::CFG_REF_DAY:    ref_reg.day    <= wr_data[calclk_pkg::DayW-1:0];
                calclk_pkg::CFG_REF_HOUR:   ref_reg.hour   <= wr_data[calclk_pkg::HourW-1:0];
                calclk_pkg::CFG_REF_MINUTE: ref_reg.minute <= wr_data[calclk_pkg::MinuteW-1:0];
                calclk_pkg::CFG_REF_SECOND: ref_reg.second <= wr_data[calclk_pkg::SecondW-1:0];
                default:                    ref_reg        <= ref_reg;
            endcase
        end
    end

    assign ref_time = ref_reg;

endmodule

@@ hw/rtl/calclk_counter.sv @@
// Time-of-day and date counters with load and one-second carry chain.
module calclk_counter
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                command,
    input  calclk_pkg::time_t   load_time,
    output calclk_pkg::time_t   time_next
);

    calclk_pkg::time_t time_reg;
    logic              leap_reg;
    logic              leap_next;

    logic              sec_wrap;
    logic              min_wrap;
    logic              hour_wrap;
    logic              day_wrap;
    logic              mon_wrap;
    calclk_pkg::time_t tick_time;

    always_comb
    begin
        sec_wrap  = (time_reg.second >= calclk_pkg::SecondMax);
        min_wrap  = (time_reg.minute >= calclk_pkg::MinuteMax);
        hour_wrap = (time_reg.hour >= calclk_pkg::HourMax);
        day_wrap  = (time_reg.day >= calclk_pkg::month_length(time_reg.month, leap_reg));
        mon_wrap  = (time_reg.month >= calclk_pkg::MonthMax);

        tick_time = time_reg;
        tick_time.second = sec_wrap ? '0 : time_reg.second + 6'd1;
        if (sec_wrap)
        begin
            tick_time.minute = min_wrap ? '0 : time_reg.minute + 6'd1;
            if (min_wrap)
            begin
                tick_time.hour = hour_wrap ? '0 : time_reg.hour + 5'd1;
                if (hour_wrap)
                begin
                    tick_time.day = day_wrap ? 5'd1 : time_reg.day + 5'd1;
                    if (day_wrap)
                    begin
                        tick_time.month = mon_wrap ? 4'd1 : time_reg.month + 4'd1;
                        if (mon_wrap)
                        begin
                            tick_time.year = (time_reg.year >= calclk_pkg::YearMax) ?
                                             '0 : time_reg.year + 14'd1;
                        end
                    end
                end
            end
        end

        time_next = (command == calclk_pkg::CMD_LOAD) ? load_time : tick_time;
        leap_next = calclk_pkg::is_leap(time_next.year);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= calclk_pkg::ResetTime;
            leap_reg <= 1'b1;
        end
        else if (advance)
        begin
            time_reg <= time_next;
            leap_reg <= leap_next;
        end
    end

    // leap flag tracks the stored year
    a_leap_track: assert property (@(posedge clk) disable iff (!rst_n)
        leap_reg == calclk_pkg::is_leap(time_reg.year))
        else $error("leap flag out of step with year");

    // plain tick below the top second only bumps the second
    a_sec_inc: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (command == calclk_pkg::CMD_TICK) &&
        (time_reg.second < calclk_pkg::SecondMax)
        |=> (time_reg.second == 6'($past(time_reg.second) + 6'd1)) &&
            $stable(time_reg.minute) && $stable(time_reg.year))
        else $error("second increment disturbed other fields");

    // a day carry always restarts at day one
    a_day_carry: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (command == calclk_pkg::CMD_TICK) && sec_wrap && min_wrap &&
        hour_wrap && day_wrap
        |=> time_reg.day == 5'd1)
        else $error("day carry did not restart at one");

endmodule

@@ hw/rtl/calendar_clock_with_compare.sv @@
// Top level: calendar clock with reference compare and registered result.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | command, load_year .. load_second
//  out     | out_valid / out_ready| now_year .. now_second, equal_flag, not_before_flag
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One item per cycle while out_ready is high; its result appears the cycle after acceptance.
//  The result register is the only register after the counter and compare logic.
//  Reset gives 2000-01-01 00:00:00 for both the time and the reference date.
//  in_ready is low only while a result waits and out_ready is low.
//  cfg_ready is always high; indexes beyond the register list are ignored.
module calendar_clock_with_compare
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic [calclk_pkg::YearW-1:0]        load_year,
    input  logic [calclk_pkg::MonthW-1:0]       load_month,
    input  logic [calclk_pkg::DayW-1:0]         load_day,
    input  logic [calclk_pkg::HourW-1:0]        load_hour,
    input  logic [calclk_pkg::MinuteW-1:0]      load_minute,
    input  logic [calclk_pkg::SecondW-1:0]      load_second,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [calclk_pkg::YearW-1:0]        now_year,
    output logic [calclk_pkg::MonthW-1:0]       now_month,
    output logic [calclk_pkg::DayW-1:0]         now_day,
    output logic [calclk_pkg::HourW-1:0]        now_hour,
    output logic [calclk_pkg::MinuteW-1:0]      now_minute,
    output logic [calclk_pkg::SecondW-1:0]      now_second,
    output logic                                equal_flag,
    output logic                                not_before_flag,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [calclk_pkg::CfgIdxW-1:0]      cfg_index,
    input  logic [calclk_pkg::CfgDataW-1:0]     cfg_data
);

    calclk_pkg::time_t ref_time;
    calclk_pkg::time_t load_time;
    calclk_pkg::time_t time_next;
    logic              accept;

    logic              out_valid_reg;
    calclk_pkg::time_t now_reg;
    logic              equal_reg;
    logic              not_before_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    assign load_time = '{
        year:   load_year,
        month:  load_month,
        day:    load_day,
        hour:   load_hour,
        minute: load_minute,
        second: load_second
    };

    calclk_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .ref_time (ref_time)
    );

    calclk_counter u_counter
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (accept),
        .command   (command),
        .load_time (load_time),
        .time_next (time_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg        <= time_next;
            equal_reg      <= (time_next == ref_time);
            not_before_reg <= (time_next >= ref_time);
        end
    end

    assign out_valid       = out_valid_reg;
    assign now_year        = now_reg.year;
    assign now_month       = now_reg.month;
    assign now_day         = now_reg.day;
    assign now_hour        = now_reg.hour;
    assign now_minute      = now_reg.minute;
    assign now_second      = now_reg.second;
    assign equal_flag      = equal_reg;
    assign not_before_flag = not_before_reg;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted item produced no result");

    a_equal_implies: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && equal_flag |-> not_before_flag)
        else $error("equal without not-before");

    a_load_year: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (command == calclk_pkg::CMD_LOAD) |=> now_year == $past(load_year))
        else $error("loaded year not returned");

endmodule
